// ===== design/rre_pkg.sv =====
package rre_pkg;

  // Default sizing of the rectangle list and the coordinates.
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int COORD_BITS_DEF  = 16;

  // Fixed field widths of the channels.
  localparam int MODE_W     = 3;
  localparam int READ_IDX_W = 8;
  localparam int COUNT_W    = 9;

  // Operation codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLIP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic wk_direct;
    logic wk_rebuild;
    logic scan_clr;
    logic rd_scan;
    logic scan_next;
    logic keep_wr;
    logic append;
    logic commit;
    logic flip;
    logic rd_src;
    logic ld_src;
    logic calc_int;
    logic ld_piece;
    logic pc_clr;
    logic pc_next;
    logic src_next;
    logic rd_entry;
    logic ld_entry;
    logic clear_list;
  } rre_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              op_empty;
    logic              idx_ok;
    logic              scan_done;
    logic              rd_covers;
    logic              cand_covers;
    logic              src_done;
    logic              piece_on;
    logic              piece_last;
  } rre_status_t;

endpackage

// ===== design/rre_in_if.sv =====
interface rre_in_if #(
  parameter int COORD_BITS = rre_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [rre_pkg::MODE_W-1:0]        mode;
  logic signed [COORD_BITS-1:0]      x_pos;
  logic signed [COORD_BITS-1:0]      y_pos;
  logic signed [COORD_BITS-1:0]      rect_width;
  logic signed [COORD_BITS-1:0]      rect_height;
  logic [rre_pkg::READ_IDX_W-1:0]    read_index;

  modport source (
    output valid, mode, x_pos, y_pos, rect_width, rect_height, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, x_pos, y_pos, rect_width, rect_height, read_index,
    output ready
  );
endinterface

// ===== design/rre_out_if.sv =====
interface rre_out_if #(
  parameter int COORD_BITS = rre_pkg::COORD_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic [rre_pkg::COUNT_W-1:0]    entry_count;
  logic                           capacity_drop;
  logic                           entry_valid;
  logic signed [COORD_BITS-1:0]   out_x;
  logic signed [COORD_BITS-1:0]   out_y;
  logic [COORD_BITS-2:0]          out_width;
  logic [COORD_BITS-2:0]          out_height;

  modport source (
    output valid, entry_count, capacity_drop, entry_valid, out_x, out_y,
           out_width, out_height,
    input  ready
  );
  modport sink (
    input  valid, entry_count, capacity_drop, entry_valid, out_x, out_y,
           out_width, out_height,
    output ready
  );
endinterface

// ===== design/rre_ctrl.sv =====
module rre_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rre_pkg::rre_status_t status,
  output rre_pkg::rre_cmd_t    cmd
);
  import rre_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_DISPATCH = 16'h0002,
    S_RD_WAIT  = 16'h0004,
    S_CHK_RD   = 16'h0008,
    S_CHK_EV   = 16'h0010,
    S_CMP_RD   = 16'h0020,
    S_CMP_EV   = 16'h0040,
    S_APPEND   = 16'h0080,
    S_ADD_FIN  = 16'h0100,
    S_SRC_RD   = 16'h0200,
    S_SRC_LD   = 16'h0400,
    S_SRC_INT  = 16'h0800,
    S_PC       = 16'h1000,
    S_PC_NEXT  = 16'h2000,
    S_RB_FIN   = 16'h4000,
    S_RESP     = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   in_rb, in_rb_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      in_rb <= 1'b0;
    end else begin
      state <= state_next;
      in_rb <= in_rb_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    in_rb_next = in_rb;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.mode)
          MODE_ADD: begin
            if (status.op_empty) begin
              state_next = S_RESP;
            end else begin
              cmd.wk_direct = 1'b1;
              cmd.scan_clr  = 1'b1;
              in_rb_next    = 1'b0;
              state_next    = S_CHK_RD;
            end
          end
          MODE_SUB: begin
            if (status.op_empty) begin
              state_next = S_RESP;
            end else begin
              cmd.wk_rebuild = 1'b1;
              in_rb_next     = 1'b1;
              state_next     = S_SRC_RD;
            end
          end
          MODE_CLIP: begin
            cmd.wk_rebuild = 1'b1;
            in_rb_next     = 1'b1;
            state_next     = S_SRC_RD;
          end
          MODE_CLEAR: begin
            cmd.clear_list = 1'b1;
            state_next     = S_RESP;
          end
          MODE_READ: begin
            if (status.idx_ok) begin
              cmd.rd_entry = 1'b1;
              state_next   = S_RD_WAIT;
            end else begin
              state_next = S_RESP;
            end
          end
          default: state_next = S_RESP;
        endcase
      end
      S_RD_WAIT: begin
        cmd.ld_entry = 1'b1;
        state_next   = S_RESP;
      end
      // First pass: is the candidate already covered by one entry?
      S_CHK_RD: begin
        if (status.scan_done) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_CMP_RD;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_CHK_EV;
        end
      end
      S_CHK_EV: begin
        if (status.rd_covers) begin
          state_next = in_rb ? S_PC_NEXT : S_ADD_FIN;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_CHK_RD;
        end
      end
      // Second pass: compact away entries the candidate covers.
      S_CMP_RD: begin
        if (status.scan_done) begin
          state_next = S_APPEND;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        cmd.keep_wr   = !status.cand_covers;
        cmd.scan_next = 1'b1;
        state_next    = S_CMP_RD;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = in_rb ? S_PC_NEXT : S_ADD_FIN;
      end
      S_ADD_FIN: begin
        cmd.commit = 1'b1;
        state_next = S_RESP;
      end
      // Rebuild: walk the source list one entry at a time.
      S_SRC_RD: begin
        if (status.src_done) begin
          state_next = S_RB_FIN;
        end else begin
          cmd.rd_src = 1'b1;
          state_next = S_SRC_LD;
        end
      end
      S_SRC_LD: begin
        cmd.ld_src = 1'b1;
        state_next = S_SRC_INT;
      end
      S_SRC_INT: begin
        cmd.calc_int = 1'b1;
        cmd.pc_clr   = 1'b1;
        state_next   = S_PC;
      end
      S_PC: begin
        if (status.piece_on) begin
          cmd.ld_piece = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_CHK_RD;
        end else begin
          state_next = S_PC_NEXT;
        end
      end
      S_PC_NEXT: begin
        if (status.piece_last) begin
          cmd.src_next = 1'b1;
          state_next   = S_SRC_RD;
        end else begin
          cmd.pc_next = 1'b1;
          state_next  = S_PC;
        end
      end
      S_RB_FIN: begin
        cmd.commit = 1'b1;
        cmd.flip   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/rre_dpath.sv =====
module rre_dpath #(
  parameter int MAX_ENTRIES = rre_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = rre_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rre_pkg::rre_cmd_t                 cmd,
  output rre_pkg::rre_status_t              status,
  input  logic [rre_pkg::MODE_W-1:0]        mode,
  input  logic signed [COORD_BITS-1:0]      x_pos,
  input  logic signed [COORD_BITS-1:0]      y_pos,
  input  logic signed [COORD_BITS-1:0]      rect_width,
  input  logic signed [COORD_BITS-1:0]      rect_height,
  input  logic [rre_pkg::READ_IDX_W-1:0]    read_index,
  output logic [rre_pkg::COUNT_W-1:0]       entry_count,
  output logic                              capacity_drop,
  output logic                              entry_valid,
  output logic signed [COORD_BITS-1:0]      out_x,
  output logic signed [COORD_BITS-1:0]      out_y,
  output logic [COORD_BITS-2:0]             out_width,
  output logic [COORD_BITS-2:0]             out_height
);
  import rre_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int E     = C + 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH = 2 * MAX_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = 4 * C - 2;
  localparam int KW    = (CW > READ_IDX_W) ? CW : READ_IDX_W;

  // Two banks of the list; the inactive one receives a rebuilt list.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;

  // Operand of the current item.
  logic [MODE_W-1:0]     op_mode;
  logic signed [C-1:0]   op_x, op_y, op_w, op_h;
  logic [READ_IDX_W-1:0] op_idx;

  // List bookkeeping.
  logic          active, wbank;
  logic [CW-1:0] stored, wcnt, sc_i, sc_j, si;
  logic [1:0]    pc;
  logic          drop;

  // Source entry, intersection and candidate.
  logic signed [C-1:0] r_x, r_y, ix, iy, c_x, c_y;
  logic [C-2:0]        r_w, r_h, c_w, c_h;
  logic signed [E-1:0] ex, ey, rxe, rye;

  // Read beat payload.
  logic                rs_valid;
  logic signed [C-1:0] rs_x, rs_y;
  logic [C-2:0]        rs_w, rs_h;

  // Combinational views.
  logic signed [C-1:0] m_x, m_y;
  logic [C-2:0]        m_w, m_h;
  logic signed [E-1:0] m_xe, m_ye, c_xe, c_ye, r_xe_c, r_ye_c, s_xe, s_ye;
  logic signed [E:0]   iw, ih;
  logic                overlap;
  logic [3:0]          mask;
  logic signed [C-1:0] p_x, p_y;
  logic signed [E-1:0] p_w, p_h;
  logic [AW-1:0]       raddr, waddr;
  logic [EW-1:0]       wdata;
  logic                rd_en, wr_en;

  function automatic logic [AW-1:0] addr_of(input logic bank, input logic [CW-1:0] idx);
    logic [AW-1:0] base;
    base = bank ? AW'(MAX_ENTRIES) : '0;
    return base + AW'(idx);
  endfunction

  function automatic logic signed [E-1:0] sx(input logic signed [C-1:0] v);
    return $signed({v[C-1], v});
  endfunction

  function automatic logic signed [E-1:0] uz(input logic [C-2:0] v);
    return $signed({2'b00, v});
  endfunction

  // Field split of the memory read data.
  assign m_x = rdata[EW-1 -: C];
  assign m_y = rdata[EW-1-C -: C];
  assign m_w = rdata[2*C-3 -: C-1];
  assign m_h = rdata[C-2:0];

  // Right and bottom edges, formed one bit wider than a coordinate.
  assign m_xe   = sx(m_x) + uz(m_w);
  assign m_ye   = sx(m_y) + uz(m_h);
  assign c_xe   = sx(c_x) + uz(c_w);
  assign c_ye   = sx(c_y) + uz(c_h);
  assign r_xe_c = sx(r_x) + uz(r_w);
  assign r_ye_c = sx(r_y) + uz(r_h);
  assign s_xe   = sx(op_x) + sx(op_w);
  assign s_ye   = sx(op_y) + sx(op_h);

  // Overlap size of the source entry and the operand.
  assign iw      = $signed({ex[E-1], ex}) - $signed({ix[C-1], ix[C-1], ix});
  assign ih      = $signed({ey[E-1], ey}) - $signed({iy[C-1], iy[C-1], iy});
  assign overlap = (iw > 0) && (ih > 0);

  // Which pieces an entry yields: top, bottom, left, right in that order.
  always_comb begin
    if (op_mode == MODE_CLIP) begin
      mask = {3'b000, overlap};
    end else if (!overlap) begin
      mask = 4'b0001;
    end else begin
      mask = {rxe > ex, r_x < ix, rye > ey, r_y < iy};
    end
  end

  // Piece selection.
  always_comb begin
    p_x = r_x;
    p_y = r_y;
    p_w = uz(r_w);
    p_h = uz(r_h);
    if (op_mode == MODE_CLIP) begin
      p_x = ix;
      p_y = iy;
      p_w = iw[E-1:0];
      p_h = ih[E-1:0];
    end else if (overlap) begin
      unique case (pc)
        2'd0: begin
          p_h = sx(iy) - sx(r_y);
        end
        2'd1: begin
          p_y = ey[C-1:0];
          p_h = rye - ey;
        end
        2'd2: begin
          p_y = iy;
          p_w = sx(ix) - sx(r_x);
          p_h = ih[E-1:0];
        end
        2'd3: begin
          p_x = ex[C-1:0];
          p_y = iy;
          p_w = rxe - ex;
          p_h = ih[E-1:0];
        end
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    status.mode        = op_mode;
    status.op_empty    = (op_w <= 0) || (op_h <= 0);
    status.idx_ok      = KW'(op_idx) < KW'(stored);
    status.scan_done   = (sc_i == wcnt);
    status.rd_covers   = (m_x <= c_x) && (m_y <= c_y) && (m_xe >= c_xe) && (m_ye >= c_ye);
    status.cand_covers = (c_x <= m_x) && (c_y <= m_y) && (c_xe >= m_xe) && (c_ye >= m_ye);
    status.src_done    = (si == stored);
    status.piece_on    = mask[pc];
    status.piece_last  = (pc == 2'd3);
  end

  // Memory port selection.
  always_comb begin
    rd_en = cmd.rd_scan || cmd.rd_src || cmd.rd_entry;
    if (cmd.rd_src) begin
      raddr = addr_of(active, si);
    end else if (cmd.rd_entry) begin
      raddr = addr_of(active, CW'(op_idx));
    end else begin
      raddr = addr_of(wbank, sc_i);
    end
    wr_en = cmd.keep_wr || (cmd.append && (sc_j < CW'(MAX_ENTRIES)));
    waddr = addr_of(wbank, sc_j);
    wdata = cmd.keep_wr ? rdata : {c_x, c_y, c_w, c_h};
  end

  // Memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Control registers of the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      stored <= '0;
    end else begin
      if (cmd.commit) begin
        stored <= wcnt;
      end else if (cmd.clear_list) begin
        stored <= '0;
      end
      if (cmd.flip) begin
        active <= !active;
      end
    end
  end

  // Operand, scan counters and working registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_mode  <= mode;
      op_x     <= x_pos;
      op_y     <= y_pos;
      op_w     <= rect_width;
      op_h     <= rect_height;
      op_idx   <= read_index;
      drop     <= 1'b0;
      rs_valid <= 1'b0;
      rs_x     <= '0;
      rs_y     <= '0;
      rs_w     <= '0;
      rs_h     <= '0;
    end
    if (cmd.wk_direct) begin
      wbank <= active;
      wcnt  <= stored;
      c_x   <= op_x;
      c_y   <= op_y;
      c_w   <= op_w[C-2:0];
      c_h   <= op_h[C-2:0];
    end
    if (cmd.wk_rebuild) begin
      wbank <= !active;
      wcnt  <= '0;
      si    <= '0;
    end
    if (cmd.scan_clr) begin
      sc_i <= '0;
      sc_j <= '0;
    end
    if (cmd.scan_next) begin
      sc_i <= sc_i + 1'b1;
    end
    if (cmd.keep_wr) begin
      sc_j <= sc_j + 1'b1;
    end
    if (cmd.append) begin
      if (sc_j < CW'(MAX_ENTRIES)) begin
        wcnt <= sc_j + 1'b1;
      end else begin
        wcnt <= sc_j;
        drop <= 1'b1;
      end
    end
    if (cmd.ld_src) begin
      r_x <= m_x;
      r_y <= m_y;
      r_w <= m_w;
      r_h <= m_h;
    end
    if (cmd.calc_int) begin
      ix  <= (r_x > op_x) ? r_x : op_x;
      iy  <= (r_y > op_y) ? r_y : op_y;
      ex  <= (r_xe_c < s_xe) ? r_xe_c : s_xe;
      ey  <= (r_ye_c < s_ye) ? r_ye_c : s_ye;
      rxe <= r_xe_c;
      rye <= r_ye_c;
    end
    if (cmd.pc_clr) begin
      pc <= 2'd0;
    end
    if (cmd.pc_next) begin
      pc <= pc + 2'd1;
    end
    if (cmd.ld_piece) begin
      c_x <= p_x;
      c_y <= p_y;
      c_w <= p_w[C-2:0];
      c_h <= p_h[C-2:0];
    end
    if (cmd.src_next) begin
      si <= si + 1'b1;
    end
    if (cmd.ld_entry) begin
      rs_valid <= 1'b1;
      rs_x     <= m_x;
      rs_y     <= m_y;
      rs_w     <= m_w;
      rs_h     <= m_h;
    end
  end

  // Result beat payload.
  assign entry_count   = COUNT_W'(stored);
  assign capacity_drop = drop;
  assign entry_valid   = rs_valid;
  assign out_x         = rs_x;
  assign out_y         = rs_y;
  assign out_width     = rs_w;
  assign out_height    = rs_h;

endmodule

// ===== design/rectangle_region_engine_core.sv =====
// Clear, no-op and an empty subtract go straight to the result beat; read first fetches
// the entry from memory. Add makes two scans over the list on one memory read port.
// Subtract and intersect walk every source entry, test four piece slots per entry and
// add each piece that is present to the new list in the way an add does.
// One item is in work at a time.
// Reset empties the list and selects bank zero; the memory itself is not cleared.
module rectangle_region_engine_core #(
  parameter int MAX_ENTRIES = rre_pkg::MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = rre_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  rre_in_if.sink    req,
  rre_out_if.source rsp
);
  import rre_pkg::*;

  rre_cmd_t    cmd;
  rre_status_t status;

  // Sequencer of the operations.
  rre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // List storage, comparators and result registers.
  rre_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .mode          (req.mode),
    .x_pos         (req.x_pos),
    .y_pos         (req.y_pos),
    .rect_width    (req.rect_width),
    .rect_height   (req.rect_height),
    .read_index    (req.read_index),
    .entry_count   (rsp.entry_count),
    .capacity_drop (rsp.capacity_drop),
    .entry_valid   (rsp.entry_valid),
    .out_x         (rsp.out_x),
    .out_y         (rsp.out_y),
    .out_width     (rsp.out_width),
    .out_height    (rsp.out_height)
  );

endmodule

// ===== tb/tb_rectangle_region_engine_core.sv =====
module tb_rectangle_region_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rre_pkg::*;

  localparam int NUM_SLOTS = MAX_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 1000000;
  localparam int RSP_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 200;
  // Lowest of the mode values that the block treats as no operation.
  localparam logic [MODE_W-1:0] MODE_SPARE = MODE_READ + 3'd1;

  // One request beat and one response beat.
  typedef struct {
    logic [MODE_W-1:0] mode;
    shortint           x;
    shortint           y;
    shortint           w;
    shortint           h;
    byte unsigned      idx;
  } region_op_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic               drop;
    logic               ev;
    logic [15:0]        ox;
    logic [15:0]        oy;
    logic [14:0]        ow;
    logic [14:0]        oh;
  } region_rsp_t;

  // Directed rows; where typed is set, the expected response is written out here.
  typedef struct {
    region_op_t  op;
    bit          typed;
    region_rsp_t rsp;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rre_in_if  #(.COORD_BITS(COORD_BITS_DEF)) req_ch ();
  rre_out_if #(.COORD_BITS(COORD_BITS_DEF)) rsp_ch ();

  rectangle_region_engine_core #(
    .MAX_ENTRIES(MAX_ENTRIES_DEF),
    .COORD_BITS (COORD_BITS_DEF)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the two rectangle banks.
  longint      shadow_x [2][NUM_SLOTS];
  longint      shadow_y [2][NUM_SLOTS];
  longint      shadow_w [2][NUM_SLOTS];
  longint      shadow_h [2][NUM_SLOTS];
  int          shadow_bank;
  int          shadow_count;
  region_rsp_t pending_rsps[$];

  int idle_pct;
  int stall_pct;
  bit hold_req;
  int hold_left;
  int mismatches;
  int idle_cycles;

  function automatic longint wrap_coord(longint v);
    logic [15:0] t;
    t = v[15:0];
    return longint'($signed(t));
  endfunction

  // Add with covering rules into one bank; returns 1 when the list is full.
  function automatic bit merge_rect(int b, ref int n, input longint x, longint y,
                                    longint w, longint h);
    longint x2, y2;
    int j;
    if (w <= 0 || h <= 0) return 1'b0;
    x = wrap_coord(x);
    y = wrap_coord(y);
    x2 = x + w;
    y2 = y + h;
    for (int i = 0; i < n; i++)
      if (shadow_x[b][i] <= x && shadow_y[b][i] <= y &&
          shadow_x[b][i] + shadow_w[b][i] >= x2 && shadow_y[b][i] + shadow_h[b][i] >= y2)
        return 1'b0;
    j = 0;
    for (int i = 0; i < n; i++) begin
      if (!(x <= shadow_x[b][i] && y <= shadow_y[b][i] &&
            x2 >= shadow_x[b][i] + shadow_w[b][i] &&
            y2 >= shadow_y[b][i] + shadow_h[b][i])) begin
        shadow_x[b][j] = shadow_x[b][i];
        shadow_y[b][j] = shadow_y[b][i];
        shadow_w[b][j] = shadow_w[b][i];
        shadow_h[b][j] = shadow_h[b][i];
        j++;
      end
    end
    n = j;
    if (n >= NUM_SLOTS) return 1'b1;
    shadow_x[b][n] = x;
    shadow_y[b][n] = y;
    shadow_w[b][n] = w;
    shadow_h[b][n] = h;
    n++;
    return 1'b0;
  endfunction

  // Subtract or clip: rebuild the list into the other bank.
  function automatic bit rebuild_region(bit clip, longint sx, longint sy, longint sw,
                                        longint sh);
    int src, dst, n;
    bit drop;
    longint rx, ry, rw, rh, ix, iy, ex, ey, iw, ih;
    src = shadow_bank;
    dst = src ^ 1;
    n = 0;
    drop = 1'b0;
    for (int i = 0; i < shadow_count; i++) begin
      rx = shadow_x[src][i];
      ry = shadow_y[src][i];
      rw = shadow_w[src][i];
      rh = shadow_h[src][i];
      ix = rx > sx ? rx : sx;
      iy = ry > sy ? ry : sy;
      ex = (rx + rw) < (sx + sw) ? (rx + rw) : (sx + sw);
      ey = (ry + rh) < (sy + sh) ? (ry + rh) : (sy + sh);
      iw = ex - ix;
      ih = ey - iy;
      if (clip) begin
        if (iw > 0 && ih > 0) drop |= merge_rect(dst, n, ix, iy, iw, ih);
      end else if (iw <= 0 || ih <= 0) begin
        drop |= merge_rect(dst, n, rx, ry, rw, rh);
      end else begin
        // Top, bottom, left and right pieces around the overlap.
        if (ry < iy) drop |= merge_rect(dst, n, rx, ry, rw, iy - ry);
        if (ry + rh > iy + ih)
          drop |= merge_rect(dst, n, rx, iy + ih, rw, (ry + rh) - (iy + ih));
        if (rx < ix) drop |= merge_rect(dst, n, rx, iy, ix - rx, ih);
        if (rx + rw > ix + iw)
          drop |= merge_rect(dst, n, ix + iw, iy, (rx + rw) - (ix + iw), ih);
      end
    end
    shadow_bank = dst;
    shadow_count = n;
    return drop;
  endfunction

  function automatic region_rsp_t apply_region_op(region_op_t op);
    region_rsp_t r;
    r = '{default: '0};
    case (op.mode)
      MODE_ADD: r.drop = merge_rect(shadow_bank, shadow_count, op.x, op.y, op.w, op.h);
      MODE_SUB:
        if (op.w > 0 && op.h > 0)
          r.drop = rebuild_region(1'b0, op.x, op.y, op.w, op.h);
      MODE_CLIP: r.drop = rebuild_region(1'b1, op.x, op.y, op.w, op.h);
      MODE_CLEAR: shadow_count = 0;
      MODE_READ: begin
        if (op.idx < shadow_count) begin
          r.ev = 1'b1;
          r.ox = shadow_x[shadow_bank][op.idx][15:0];
          r.oy = shadow_y[shadow_bank][op.idx][15:0];
          r.ow = shadow_w[shadow_bank][op.idx][14:0];
          r.oh = shadow_h[shadow_bank][op.idx][14:0];
        end
      end
      default: ;
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  // Drive one request beat and record its expected response once it is taken.
  task automatic send_op(region_op_t op, bit typed = 1'b0,
                         region_rsp_t typed_rsp = '{default: '0});
    region_rsp_t r;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.mode        = op.mode;
    req_ch.x_pos       = op.x;
    req_ch.y_pos       = op.y;
    req_ch.rect_width  = op.w;
    req_ch.rect_height = op.h;
    req_ch.read_index  = op.idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    r = apply_region_op(op);
    pending_rsps.push_back(typed ? typed_rsp : r);
    @(negedge clk);
  endtask

  task automatic drain_pending();
    req_ch.valid = 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk);
  endtask

  function automatic region_op_t make_random_op();
    region_op_t op;
    int pick;
    pick = $urandom_range(99);
    if (shadow_count > 40) op.mode = MODE_CLEAR;
    else if (pick < 40) op.mode = MODE_ADD;
    else if (pick < 55) op.mode = MODE_SUB;
    else if (pick < 63) op.mode = MODE_CLIP;
    else if (pick < 68) op.mode = MODE_CLEAR;
    else if (pick < 95) op.mode = MODE_READ;
    else op.mode = MODE_SPARE + 3'($urandom_range(2));
    // Rebuilds cost about the square of the list length, so keep those lists short.
    if ((op.mode == MODE_SUB || op.mode == MODE_CLIP) && shadow_count > 16) op.mode = MODE_ADD;
    if ($urandom_range(99) < 85) begin
      op.x = shortint'($urandom_range(80)) - 16'sd40;
      op.y = shortint'($urandom_range(80)) - 16'sd40;
      op.w = shortint'($urandom_range(34)) - 16'sd4;
      op.h = shortint'($urandom_range(34)) - 16'sd4;
    end else begin
      op.x = shortint'($urandom());
      op.y = shortint'($urandom());
      op.w = shortint'($urandom());
      op.h = shortint'($urandom());
    end
    if ($urandom_range(99) < 80)
      op.idx = byte'($urandom_range(shadow_count + 2 > 255 ? 255 : shadow_count + 2));
    else op.idx = byte'($urandom());
    return op;
  endfunction

  // Response side: random stalls, plus a long counted hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = RSP_HOLD_CYCLES;
      rsp_ch.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every response beat with the oldest expectation.
  always @(posedge clk) begin
    region_rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("response beat with nothing expected at %0t", $realtime);
      end else begin
        e = pending_rsps.pop_front();
        if (rsp_ch.entry_count !== e.count || rsp_ch.capacity_drop !== e.drop ||
            rsp_ch.entry_valid !== e.ev || rsp_ch.out_x !== e.ox || rsp_ch.out_y !== e.oy ||
            rsp_ch.out_width !== e.ow || rsp_ch.out_height !== e.oh) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp cnt=%0d drop=%0b ev=%0b x=%0d y=%0d w=%0d h=%0d,",
                      " got cnt=%0d drop=%0b ev=%0b x=%0d y=%0d w=%0d h=%0d"},
                     $realtime, e.count, e.drop, e.ev, $signed(e.ox), $signed(e.oy), e.ow, e.oh,
                     rsp_ch.entry_count, rsp_ch.capacity_drop, rsp_ch.entry_valid,
                     rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_width, rsp_ch.out_height);
        end
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rectangle_region_engine_core failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  directed_row_t directed_rows[] = '{
    '{'{MODE_READ,  0, 0, 0, 0, 0}, 1'b1, '{default: '0}},
    '{'{MODE_ADD,   3, 3, 0, 5, 0}, 1'b1, '{default: '0}},
    '{'{MODE_ADD,   3, 3, 5, -16'sd32768, 0}, 1'b1, '{default: '0}},
    '{'{MODE_ADD,   0, 0, 10, 10, 0}, 1'b0, '{default: '0}},
    '{'{MODE_ADD,   2, 2, 3, 3, 0}, 1'b0, '{default: '0}},
    '{'{MODE_ADD,   20, 20, 4, 4, 0}, 1'b0, '{default: '0}},
    '{'{MODE_ADD,   -5, -5, 20, 20, 0}, 1'b0, '{default: '0}},
    '{'{MODE_ADD,   32000, -16'sd32768, 32767, 32767, 0}, 1'b0, '{default: '0}},
    '{'{MODE_SUB,   0, 0, 0, 5, 0}, 1'b0, '{default: '0}},
    '{'{MODE_SUB,   0, 0, 5, 5, 0}, 1'b0, '{default: '0}},
    '{'{MODE_SUB,   32700, -100, 200, 50, 0}, 1'b0, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 3}, 1'b0, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 5}, 1'b0, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 255}, 1'b0, '{default: '0}},
    '{'{MODE_SPARE, 1, 1, 1, 1, 1}, 1'b0, '{default: '0}},
    '{'{MODE_SPARE + 3'd2, -1, -1, -1, -1, 255}, 1'b0, '{default: '0}},
    '{'{MODE_CLIP,  -2, -2, 8, 8, 0}, 1'b0, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 0}, 1'b0, '{default: '0}},
    '{'{MODE_CLIP,  0, 0, -1, 8, 0}, 1'b1, '{default: '0}},
    '{'{MODE_ADD,   -16'sd32768, -16'sd32768, 32767, 32767, 0}, 1'b0, '{default: '0}},
    '{'{MODE_CLEAR, 0, 0, 0, 0, 0}, 1'b1, '{default: '0}},
    '{'{MODE_READ,  0, 0, 0, 0, 0}, 1'b1, '{default: '0}}
  };

  initial begin
    region_op_t op;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_ADD;
    req_ch.x_pos = '0;
    req_ch.y_pos = '0;
    req_ch.rect_width = '0;
    req_ch.rect_height = '0;
    req_ch.read_index = '0;
    rsp_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    hold_left = 0;
    mismatches = 0;
    idle_cycles = 0;
    shadow_bank = 0;
    shadow_count = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows.
    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].rsp);
    drain_pending();

    // Fill the list: a row of squares, then three horizontal cuts split every square
    // into four strips. Then overflow it by one.
    idle_pct = 8;
    stall_pct = 8;
    for (int i = 0; i < NUM_SLOTS / 4; i++) begin
      op = '{MODE_ADD, shortint'(i * 30), 0, 20, 20, 0};
      send_op(op);
    end
    op = '{MODE_SUB, -10, 5, 2000, 5, 0};
    send_op(op);
    op = '{MODE_SUB, -10, 2, 2000, 1, 0};
    send_op(op);
    op = '{MODE_SUB, -10, 14, 2000, 1, 0};
    send_op(op);
    op = '{MODE_READ, 0, 0, 0, 0, 255};
    send_op(op);
    op = '{MODE_ADD, 3000, 3000, 5, 5, 0};
    send_op(op);
    op = '{MODE_CLEAR, 0, 0, 0, 0, 0};
    send_op(op);
    drain_pending();

    // Random items in four idling phases; the sender waits for all responses between.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % (RANDOM_ITEMS / 4) == 0) begin
        drain_pending();
        case (i / (RANDOM_ITEMS / 4))
          0: begin idle_pct = 0; stall_pct = 0; end
          1: begin idle_pct = 66; stall_pct = 0; end
          2: begin idle_pct = 0; stall_pct = 66; end
          default: begin idle_pct = 8; stall_pct = 8; end
        endcase
      end
      if (i == 20) hold_req = 1'b1;
      send_op(make_random_op());
    end
    drain_pending();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("tb_rectangle_region_engine_core passed");
    end else begin
      $display("tb_rectangle_region_engine_core failed");
    end
    $finish;
  end

endmodule

// ===== rectangle_region_engine_core.f =====
design/rre_pkg.sv
design/rre_in_if.sv
design/rre_out_if.sv
design/rre_ctrl.sv
design/rre_dpath.sv
design/rectangle_region_engine_core.sv
tb/tb_rectangle_region_engine_core.sv
